>>> hdl/npvl_pkg.sv
// ----------------------------------------------------------------------------
// npvl_pkg
// Shared types and constants of the nearest point velocity lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package npvl_pkg;

  localparam int NPVL_TABLE_DEPTH = 256;

  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 64;

  localparam int COORD_W = 24;
  localparam int SPEED_W = 16;
  localparam int POINT_W = 3 * COORD_W;
  localparam int VEL_W   = 3 * SPEED_W;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int DIST_W  = SQ_W + 2;
  localparam int TOL_W   = 52;
  localparam int EU_W    = 9;
  localparam int NIDX_W  = 8;

  localparam logic [EU_W-1:0]  ENTRIES_RESET = 9'd256;
  localparam logic [TOL_W-1:0] TOL_RESET     = 52'd1678;

  // Item kinds carried on in_tuser.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Register select, taken from the byte address bit 3.
  localparam logic CFG_IDX_ENTRIES = 1'b0;
  localparam logic CFG_IDX_TOL     = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_VEL_RD,
    ST_RESULT
  } npvl_state_t;

  // Control that travels alongside each entry in the distance pipeline.
  typedef struct packed {
    logic vld;
    logic last;
  } npvl_tag_t;

endpackage

`default_nettype wire

>>> hdl/npvl_dist.sv
// ----------------------------------------------------------------------------
// npvl_dist
// Three-stage squared Euclidean distance pipeline: difference, square, sum.
// ----------------------------------------------------------------------------
`default_nettype none

module npvl_dist
  import npvl_pkg::*;
#(
  parameter int IDX_W = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire npvl_tag_t                   in_tag,
  input  wire logic        [IDX_W-1:0]     in_idx,
  input  wire logic        [POINT_W-1:0]   entry_point,  // x, y, z from bit 0 up
  input  wire logic signed [COORD_W-1:0]   query_x,
  input  wire logic signed [COORD_W-1:0]   query_y,
  input  wire logic signed [COORD_W-1:0]   query_z,
  output npvl_tag_t                        out_tag,
  output logic             [IDX_W-1:0]     out_idx,
  output logic             [DIST_W-1:0]    out_dist
);

  npvl_tag_t tag1_r, tag2_r, tag3_r;
  logic [IDX_W-1:0] idx1_r, idx2_r, idx3_r;

  logic signed [DIFF_W-1:0] dx_nxt, dy_nxt, dz_nxt;
  logic signed [DIFF_W-1:0] dx_r, dy_r, dz_r;
  logic signed [2*DIFF_W-1:0] px, py, pz;
  logic [SQ_W-1:0] sx_r, sy_r, sz_r;
  logic [DIST_W-1:0] dist_r;

  // Sign-extended differences are exact in one extra bit.
  assign dx_nxt = {query_x[COORD_W-1], query_x}
                - {entry_point[COORD_W-1], entry_point[COORD_W-1:0]};
  assign dy_nxt = {query_y[COORD_W-1], query_y}
                - {entry_point[2*COORD_W-1], entry_point[2*COORD_W-1:COORD_W]};
  assign dz_nxt = {query_z[COORD_W-1], query_z}
                - {entry_point[3*COORD_W-1], entry_point[3*COORD_W-1:2*COORD_W]};

  assign px = dx_r * dx_r;
  assign py = dy_r * dy_r;
  assign pz = dz_r * dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
    end else begin
      tag1_r <= in_tag;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
    end
  end

  always_ff @(posedge clk) begin
    idx1_r <= in_idx;
    idx2_r <= idx1_r;
    idx3_r <= idx2_r;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    dz_r   <= dz_nxt;
    // A square of a difference below 2^24 in magnitude fits in 48 bits.
    sx_r   <= px[SQ_W-1:0];
    sy_r   <= py[SQ_W-1:0];
    sz_r   <= pz[SQ_W-1:0];
    dist_r <= DIST_W'(sx_r) + DIST_W'(sy_r) + DIST_W'(sz_r);
  end

  assign out_tag  = tag3_r;
  assign out_idx  = idx3_r;
  assign out_dist = dist_r;

endmodule

`default_nettype wire

>>> hdl/nearest_point_velocity_lookup_core.sv
// ----------------------------------------------------------------------------
// nearest_point_velocity_lookup_core
// Table of 3-D points with velocities; a query returns the velocity of the
// nearest stored point when it lies within the squared tolerance.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload
//  in_     | slave     | tuser: operation; tdata: entry index, point, velocity
//  out_    | master    | tuser: found; tdata: nearest index, velocity
//  cfg_    | APB slave | entries_used at 0x0, tolerance_squared at 0x8
//
//  A query scans n entries, where n is entries_used clamped to 1 .. TABLE_DEPTH,
//  through the single read port of the point memory that delivers one entry
//  per cycle.
//  After reset both memories are cleared, one entry per cycle; no item is
//  accepted meanwhile.
//  One item is in work at a time. A finished result waits in the output
//  register, and the next item is accepted while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_point_velocity_lookup_core
  import npvl_pkg::*;
#(
  parameter int TABLE_DEPTH = NPVL_TABLE_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // entry_index[7:0], point_x[31:8], point_y[55:32], point_z[79:56],
  // speed_u[95:80], speed_v[111:96], speed_w[127:112]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // operation[0]
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // nearest_index[7:0], result_u[23:8], result_v[39:24], result_w[55:40]
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // found[0]
  output logic                       out_tuser,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CMP_W   = (IDX_W + 1 > EU_W) ? IDX_W + 1 : EU_W;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [CMP_W-1:0] DEPTH_C   = CMP_W'(TABLE_DEPTH);

  // Configuration
  logic [EU_W-1:0]  entries_used_r;
  logic [TOL_W-1:0] tol_r;
  logic             cfg_wr;

  // Control
  npvl_state_t state_r, state_nxt;
  logic [IDX_W-1:0] clr_idx_r;
  logic [IDX_W-1:0] scan_idx_r;
  logic [IDX_W-1:0] last_idx_r, last_idx_nxt;
  logic             in_acc, is_query, wr_item, wr_in_range;
  logic             clr_we, pt_ren, sp_ren, res_load;

  // Memories
  logic [POINT_W-1:0] pt_mem [TABLE_DEPTH];
  logic [VEL_W-1:0]   sp_mem [TABLE_DEPTH];
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [POINT_W-1:0] pt_wdata;
  logic [VEL_W-1:0]   sp_wdata;
  logic [POINT_W-1:0] pt_rdata_r;
  logic [VEL_W-1:0]   sp_rdata_r;
  npvl_tag_t          rd_tag_r;
  logic [IDX_W-1:0]   rd_idx_r;

  // Query point
  logic signed [COORD_W-1:0] q_x_r, q_y_r, q_z_r;
  logic [CMP_W-1:0] wr_slot_ext, eu_ext, last_ext;

  // Distance results and best so far
  npvl_tag_t         dist_tag;
  logic [IDX_W-1:0]  dist_idx;
  logic [DIST_W-1:0] dist_val;
  logic [DIST_W-1:0] best_d_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic [CMP_W-1:0]  best_idx_ext;
  logic              found;

  // Output register
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic                  out_tuser_r;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_used_r <= ENTRIES_RESET;
      tol_r          <= TOL_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[3])
        CFG_IDX_ENTRIES: entries_used_r <= cfg_pwdata[EU_W-1:0];
        CFG_IDX_TOL:     tol_r          <= cfg_pwdata[TOL_W-1:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3])
      CFG_IDX_ENTRIES: cfg_prdata = CFG_DATA_W'(entries_used_r);
      CFG_IDX_TOL:     cfg_prdata = CFG_DATA_W'(tol_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Item decode
  // --------------------------------------------------------------------------
  assign in_acc      = in_tvalid & in_tready;
  assign is_query    = (in_tuser == OP_QUERY);
  assign wr_slot_ext = CMP_W'(in_tdata[NIDX_W-1:0]);
  assign wr_in_range = (wr_slot_ext < DEPTH_C);
  assign wr_item     = in_acc & (in_tuser == OP_WRITE) & wr_in_range;

  // The search count is clamped to 1 .. TABLE_DEPTH.
  assign eu_ext = CMP_W'(entries_used_r);
  always_comb begin
    if (eu_ext == '0) begin
      last_ext = '0;
    end else if (eu_ext > DEPTH_C) begin
      last_ext = DEPTH_C - CMP_W'(1);
    end else begin
      last_ext = eu_ext - CMP_W'(1);
    end
    last_idx_nxt = last_ext[IDX_W-1:0];
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    clr_we    = 1'b0;
    pt_ren    = 1'b0;
    sp_ren    = 1'b0;
    res_load  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        clr_we = 1'b1;
        if (clr_idx_r == LAST_SLOT) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && is_query) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        pt_ren = 1'b1;
        if (scan_idx_r == last_idx_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (dist_tag.vld && dist_tag.last) begin
          state_nxt = ST_VEL_RD;
        end
      end
      ST_VEL_RD: begin
        sp_ren    = 1'b1;
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_tvalid_r || out_tready) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r  <= '0;
      scan_idx_r <= '0;
      last_idx_r <= '0;
    end else begin
      if (clr_we) begin
        clr_idx_r <= clr_idx_r + IDX_W'(1);
      end
      if (in_acc && is_query) begin
        scan_idx_r <= '0;
        last_idx_r <= last_idx_nxt;
      end else if (pt_ren) begin
        scan_idx_r <= scan_idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && is_query) begin
      q_x_r <= in_tdata[NIDX_W+COORD_W-1:NIDX_W];
      q_y_r <= in_tdata[NIDX_W+2*COORD_W-1:NIDX_W+COORD_W];
      q_z_r <= in_tdata[NIDX_W+3*COORD_W-1:NIDX_W+2*COORD_W];
    end
  end

  // --------------------------------------------------------------------------
  // Point and velocity memories
  // --------------------------------------------------------------------------
  assign mem_we    = clr_we | wr_item;
  assign mem_waddr = clr_we ? clr_idx_r : wr_slot_ext[IDX_W-1:0];
  assign pt_wdata  = clr_we ? '0 : in_tdata[NIDX_W+POINT_W-1:NIDX_W];
  assign sp_wdata  = clr_we ? '0 : in_tdata[NIDX_W+POINT_W+VEL_W-1:NIDX_W+POINT_W];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pt_mem[mem_waddr] <= pt_wdata;
      sp_mem[mem_waddr] <= sp_wdata;
    end
    if (pt_ren) begin
      pt_rdata_r <= pt_mem[scan_idx_r];
    end
    if (sp_ren) begin
      sp_rdata_r <= sp_mem[best_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_tag_r <= '0;
    end else begin
      rd_tag_r.vld  <= pt_ren;
      rd_tag_r.last <= pt_ren && (scan_idx_r == last_idx_r);
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= scan_idx_r;
  end

  // --------------------------------------------------------------------------
  // Distance pipeline and running minimum
  // --------------------------------------------------------------------------
  npvl_dist #(
    .IDX_W (IDX_W)
  ) u_dist (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tag      (rd_tag_r),
    .in_idx      (rd_idx_r),
    .entry_point (pt_rdata_r),
    .query_x     (q_x_r),
    .query_y     (q_y_r),
    .query_z     (q_z_r),
    .out_tag     (dist_tag),
    .out_idx     (dist_idx),
    .out_dist    (dist_val)
  );

  // Entries arrive in ascending order, so a strict compare keeps the lowest
  // index on a tie. Slot 0 always opens a new search.
  always_ff @(posedge clk) begin
    if (dist_tag.vld && ((dist_idx == '0) || (dist_val < best_d_r))) begin
      best_d_r   <= dist_val;
      best_idx_r <= dist_idx;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  assign found        = (TOL_W'(best_d_r) < tol_r);
  assign best_idx_ext = CMP_W'(best_idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_tuser_r <= found;
      out_tdata_r <= {(found ? sp_rdata_r : {VEL_W{1'b0}}), best_idx_ext[NIDX_W-1:0]};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_RESULT))
    else $error("result appeared without a finished query");

  a_no_write_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_DRAIN || state_r == ST_VEL_RD) |-> !mem_we)
    else $error("table written while a query is in progress");

  a_scan_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (scan_idx_r <= last_idx_r))
    else $error("scan index ran past the last searched entry");

  a_miss_zero_vel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[OUT_DATA_W-1:NIDX_W] == '0))
    else $error("velocity not zero on a miss");

  a_last_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (dist_tag.vld && dist_tag.last) |-> (state_r == ST_DRAIN))
    else $error("last distance arrived outside the drain phase");

endmodule

`default_nettype wire

>>> bench/nearest_point_velocity_lookup_core_tb.sv
// ----------------------------------------------------------------------------
// nearest_point_velocity_lookup_core_tb
// Self-checking bench for the nearest point velocity lookup. Table writes and
// queries are driven on the input stream. A local copy of the point and
// velocity tables predicts each query result by a full scan, and the results
// are compared field by field as they leave the block. Both stream sides idle
// at random, and the sink holds off once for a long stretch.
// ----------------------------------------------------------------------------
module nearest_point_velocity_lookup_core_tb
  import npvl_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH  = NPVL_TABLE_DEPTH;
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 16;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic        op;
    logic [7:0]  slot;
    logic [23:0] x;
    logic [23:0] y;
    logic [23:0] z;
    logic [15:0] u;
    logic [15:0] v;
    logic [15:0] w;
  } probe_item_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  idx;
    logic [15:0] u;
    logic [15:0] v;
    logic [15:0] w;
  } lookup_result_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic                  in_tuser    = OP_WRITE;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b1;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Predicted contents of the block.
  logic [23:0] tbl_x [TABLE_DEPTH];
  logic [23:0] tbl_y [TABLE_DEPTH];
  logic [23:0] tbl_z [TABLE_DEPTH];
  logic [15:0] tbl_u [TABLE_DEPTH];
  logic [15:0] tbl_v [TABLE_DEPTH];
  logic [15:0] tbl_w [TABLE_DEPTH];
  logic [EU_W-1:0]  model_entries;
  logic [TOL_W-1:0] model_tol;

  lookup_result_t pending_lookups[$];
  int lookup_errors = 0;
  bit idle_on       = 1'b1;
  int hold_requests = 0;
  int hold_taken    = 0;
  int hold_left     = 0;
  int stall_left    = 0;

  nearest_point_velocity_lookup_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int search_count();
    int n;
    n = model_entries;
    if (n < 1) n = 1;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    return n;
  endfunction

  function automatic longint unsigned point_gap_sq(input probe_item_t it, input int slot);
    longint dx, dy, dz;
    dx = longint'($signed(it.x)) - longint'($signed(tbl_x[slot]));
    dy = longint'($signed(it.y)) - longint'($signed(tbl_y[slot]));
    dz = longint'($signed(it.z)) - longint'($signed(tbl_z[slot]));
    return dx * dx + dy * dy + dz * dz;
  endfunction

  // Applies one accepted item to the predicted tables; returns 1 with the
  // expected result when the item is a query.
  function automatic bit model_accept(input probe_item_t it, output lookup_result_t res);
    longint unsigned d, best_d;
    int best_i;
    res = '0;
    if (it.op == OP_WRITE) begin
      tbl_x[it.slot] = it.x;
      tbl_y[it.slot] = it.y;
      tbl_z[it.slot] = it.z;
      tbl_u[it.slot] = it.u;
      tbl_v[it.slot] = it.v;
      tbl_w[it.slot] = it.w;
      return 1'b0;
    end
    best_i = 0;
    best_d = point_gap_sq(it, 0);
    for (int i = 1; i < search_count(); i++) begin
      d = point_gap_sq(it, i);
      // Strictly smaller only, so the lowest slot keeps a tie.
      if (d < best_d) begin
        best_d = d;
        best_i = i;
      end
    end
    res.idx = 8'(best_i);
    if (best_d < model_tol) begin
      res.found = 1'b1;
      res.u = tbl_u[best_i];
      res.v = tbl_v[best_i];
      res.w = tbl_w[best_i];
    end
    return 1'b1;
  endfunction

  function automatic probe_item_t make_item(input logic op, input int slot, input int x,
                                            input int y, input int z, input int u,
                                            input int v, input int w);
    probe_item_t it;
    it.op   = op;
    it.slot = slot[7:0];
    it.x    = x[23:0];
    it.y    = y[23:0];
    it.z    = z[23:0];
    it.u    = u[15:0];
    it.v    = v[15:0];
    it.w    = w[15:0];
    return it;
  endfunction

  // Places the item's point within +/- reach of a stored point, wrapping at
  // the coordinate width.
  function automatic void place_near(inout probe_item_t it, input int slot, input int reach);
    it.x = tbl_x[slot] + 24'($urandom_range(0, 2 * reach)) - 24'(reach);
    it.y = tbl_y[slot] + 24'($urandom_range(0, 2 * reach)) - 24'(reach);
    it.z = tbl_z[slot] + 24'($urandom_range(0, 2 * reach)) - 24'(reach);
  endfunction

  function automatic probe_item_t random_item(input int span);
    probe_item_t it;
    int pick;
    it.op = ($urandom_range(0, 9) < 4) ? OP_WRITE : OP_QUERY;
    it.slot = 8'($urandom);
    it.x = 24'($urandom);
    it.y = 24'($urandom);
    it.z = 24'($urandom);
    it.u = 16'($urandom);
    it.v = 16'($urandom);
    it.w = 16'($urandom);
    pick = $urandom_range(0, 7);
    if (it.op == OP_WRITE) begin
      if (pick != 0) it.slot = 8'($urandom_range(0, span - 1));
      // Some writes land next to a stored point to make close competitors.
      if (pick < 3) place_near(it, $urandom_range(0, span - 1), 8);
    end else if (pick < 2) begin
      place_near(it, $urandom_range(0, span - 1), 0);
    end else if (pick < 6) begin
      place_near(it, $urandom_range(0, span - 1), 32);
    end
    return it;
  endfunction

  task automatic send_item(input probe_item_t it);
    lookup_result_t res;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.op;
    in_tdata  <= {it.w, it.v, it.u, it.z, it.y, it.x, it.slot};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (model_accept(it, res)) pending_lookups.push_back(res);
  endtask

  // Waits until every query has answered and any trailing write has settled.
  task automatic drain_block();
    in_tvalid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic sel, input logic [CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {sel, 3'b000};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (sel == CFG_IDX_ENTRIES) model_entries = value[EU_W-1:0];
    else model_tol = value[TOL_W-1:0];
  endtask

  task automatic set_registers(input logic [CFG_DATA_W-1:0] entries,
                               input logic [CFG_DATA_W-1:0] tol);
    drain_block();
    cfg_write(CFG_IDX_ENTRIES, entries);
    cfg_write(CFG_IDX_TOL, tol);
  endtask

  // The table is cleared by reset, so every slot sits at the origin.
  task automatic test_cleared_table();
    send_item(make_item(OP_QUERY, 8'hFF, 0, 0, 0, 0, 0, 0));
    send_item(make_item(OP_QUERY, 8'h00, 40, 0, 0, 0, 0, 0));
    send_item(make_item(OP_QUERY, 8'h55, 8388607, 8388607, 8388607, 0, 0, 0));
    send_item(make_item(OP_QUERY, 8'hAA, -8388608, -8388608, -8388608, 0, 0, 0));
  endtask

  task automatic test_extremes_and_ties();
    send_item(make_item(OP_WRITE, 0, 8388607, 8388607, 8388607, 32767, -32768, 'h5A5A));
    send_item(make_item(OP_WRITE, 255, -8388608, -8388608, -8388608, -1, 0, 1));
    send_item(make_item(OP_WRITE, 5, -4096, 4096, 12345, 100, 200, 300));
    send_item(make_item(OP_WRITE, 9, -4096, 4096, 12345, 400, 500, 600));
    send_item(make_item(OP_WRITE, 7, 1000, -2000, 3000, -100, -200, -300));
    send_item(make_item(OP_QUERY, 3, 8388607, 8388607, 8388607, 0, 0, 0));
    send_item(make_item(OP_QUERY, 0, -8388608, -8388608, -8388608, 0, 0, 0));
    send_item(make_item(OP_QUERY, 0, -4096, 4096, 12345, 0, 0, 0));
    // Squared offsets of 1667 and 1678 sit just below and at the reset tolerance.
    send_item(make_item(OP_QUERY, 0, 1039, -1989, 3005, 0, 0, 0));
    send_item(make_item(OP_QUERY, 0, 1039, -1989, 3006, 0, 0, 0));
  endtask

  task automatic test_search_count_clamp();
    // A count of zero searches slot 0 alone; the widest tolerance matches all.
    set_registers('0, '1);
    send_item(make_item(OP_QUERY, 0, -8388608, -8388608, -8388608, 0, 0, 0));
    send_item(make_item(OP_QUERY, 0, 0, 0, 0, 0, 0, 0));
    // An oversized count searches the whole table; zero tolerance never matches.
    set_registers('1, '0);
    send_item(make_item(OP_QUERY, 0, -8388608, -8388608, -8388608, 0, 0, 0));
    send_item(make_item(OP_QUERY, 0, -4096, 4096, 12345, 0, 0, 0));
  endtask

  task automatic test_back_pressure();
    set_registers(4, 64'd1 << 20);
    hold_requests++;
    repeat (24) send_item(random_item(search_count()));
  endtask

  task automatic test_random_mix(input int count, input logic [CFG_DATA_W-1:0] entries,
                                 input logic [CFG_DATA_W-1:0] tol);
    set_registers(entries, tol);
    repeat (count) send_item(random_item(search_count()));
  endtask

  task automatic check_field(input string field, input longint unsigned exp_v,
                             input longint unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, exp_v, act_v);
      lookup_errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    lookup_result_t exp_res;
    if (out_tvalid && out_tready) begin
      if (pending_lookups.size() == 0) begin
        $display("%0t ns: result with none expected, found %0b index %0d", $time,
                 out_tuser, out_tdata[7:0]);
        lookup_errors++;
      end else begin
        exp_res = pending_lookups.pop_front();
        check_field("found", 64'(exp_res.found), 64'(out_tuser));
        check_field("nearest_index", 64'(exp_res.idx), 64'(out_tdata[7:0]));
        check_field("result_u", 64'(exp_res.u), 64'(out_tdata[23:8]));
        check_field("result_v", 64'(exp_res.v), 64'(out_tdata[39:24]));
        check_field("result_w", 64'(exp_res.w), 64'(out_tdata[55:40]));
      end
    end
    if (hold_left > 0) begin
      hold_left--;
    end else if (hold_taken != hold_requests) begin
      hold_taken++;
      hold_left = HOLD_CYCLES;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 6);
    end
    out_tready <= (hold_left == 0) && (stall_left == 0);
  end

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_x[i] = '0;
      tbl_y[i] = '0;
      tbl_z[i] = '0;
      tbl_u[i] = '0;
      tbl_v[i] = '0;
      tbl_w[i] = '0;
    end
    model_entries = ENTRIES_RESET;
    model_tol     = TOL_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_cleared_table();
    test_extremes_and_ties();
    test_search_count_clamp();
    test_back_pressure();
    test_random_mix(300, 16, 64'd1 << 24);
    test_random_mix(200, 256, 1678);
    repeat (3) begin
      test_random_mix(100, $urandom_range(2, 64),
                      {$urandom, $urandom} >> $urandom_range(12, 63));
    end
    idle_on = 1'b0;
    test_random_mix(250, 32, 64'd1 << 12);
    drain_block();

    if (lookup_errors == 0) begin
      $display("nearest_point_velocity_lookup_core test passed");
    end else begin
      $display("nearest_point_velocity_lookup_core test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("nearest_point_velocity_lookup_core test failed");
    $finish;
  end

endmodule

>>> files.f
hdl/npvl_pkg.sv
hdl/npvl_dist.sv
hdl/nearest_point_velocity_lookup_core.sv
bench/nearest_point_velocity_lookup_core_tb.sv
